/* design/lpd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package lpd_pkg;

    typedef enum logic [1:0] {
        KIND_BYTE  = 2'd0,
        KIND_EMPTY = 2'd1,
        KIND_ERROR = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ST_HEADER  = 3'b001,
        ST_PAYLOAD = 3'b010,
        ST_DROPPED = 3'b100
    } state_t;

    localparam logic [31:0] HDR_LEN           = 32'd4;
    localparam logic [1:0]  HDR_LAST_INDEX    = 2'd3;
    localparam logic [31:0] MAX_PAYLOAD_RESET = 32'd1048576;

endpackage

`default_nettype wire

/* design/length_prefix_deframer_unit.sv */
// Length-prefixed stream deframer.
// Input channel (in_valid/in_ready, rx_byte) takes one stream byte per transfer.
// Each frame opens with a 4-byte big-endian length that includes the header.
// Output channel (out_valid/out_ready) carries kind, payload_byte, frame_end:
// one transfer per payload byte, one for an empty frame, one for a length error.
// Header bytes other than an empty or bad fourth byte give no output.
// A result is registered and presented in the cycle after its byte is accepted.
// Throughput: one byte per cycle; the result register is the single stage, and
// a new byte is taken whenever that register is empty or being emptied.
// When the receiver stalls with a result pending, in_ready drops until the
// result is transferred.
// cfg_we/cfg_wdata write max_payload; it applies from the next
// completed header onward.
// After a length error every later byte is accepted and dropped until reset.
// Reset empties the output register, clears the frame state and the dropped
// condition, and sets max_payload to 1048576.
`timescale 1ns / 1ps
`default_nettype none

module length_prefix_deframer_unit (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire logic [7:0]      rx_byte,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output lpd_pkg::kind_t       kind,
    output logic [7:0]           payload_byte,
    output logic                 frame_end,
    input  wire logic            cfg_we,
    input  wire logic [31:0]     cfg_wdata
);

    import lpd_pkg::*;

    state_t      state_reg, state_next;
    logic [23:0] header_bytes_reg, header_bytes_next;
    logic [1:0]  header_index_reg, header_index_next;
    logic [31:0] bytes_left_reg, bytes_left_next;
    logic [31:0] max_payload_reg;

    logic        out_valid_reg, out_valid_next;
    kind_t       kind_reg, kind_next;
    logic [7:0]  payload_byte_reg, payload_byte_next;
    logic        frame_end_reg, frame_end_next;

    logic        in_xfer;
    logic        produce;
    logic [31:0] frame_len;

    assign in_ready  = !out_valid_reg || out_ready;
    assign in_xfer   = in_valid && in_ready;
    assign frame_len = {header_bytes_reg, rx_byte} - HDR_LEN;

    always_comb
    begin
        state_next        = state_reg;
        header_bytes_next = header_bytes_reg;
        header_index_next = header_index_reg;
        bytes_left_next   = bytes_left_reg;
        produce           = 1'b0;
        kind_next         = KIND_BYTE;
        payload_byte_next = 8'd0;
        frame_end_next    = 1'b0;
        if (in_xfer)
        begin
            case (state_reg)
                ST_PAYLOAD:
                begin
                    produce           = 1'b1;
                    payload_byte_next = rx_byte;
                    if (bytes_left_reg <= 32'd1)
                    begin
                        bytes_left_next = 32'd0;
                        state_next      = ST_HEADER;
                        frame_end_next  = 1'b1;
                    end
                    else
                    begin
                        bytes_left_next = bytes_left_reg - 32'd1;
                    end
                end
                ST_HEADER:
                begin
                    if (header_index_reg != HDR_LAST_INDEX)
                    begin
                        header_bytes_next = {header_bytes_reg[15:0], rx_byte};
                        header_index_next = header_index_reg + 2'd1;
                    end
                    else
                    begin
                        header_bytes_next = 24'd0;
                        header_index_next = 2'd0;
                        if (frame_len > max_payload_reg)
                        begin
                            state_next = ST_DROPPED;
                            produce    = 1'b1;
                            kind_next  = KIND_ERROR;
                        end
                        else if (frame_len == 32'd0)
                        begin
                            produce        = 1'b1;
                            kind_next      = KIND_EMPTY;
                            frame_end_next = 1'b1;
                        end
                        else
                        begin
                            bytes_left_next = frame_len;
                            state_next      = ST_PAYLOAD;
                        end
                    end
                end
                ST_DROPPED:
                begin
                    state_next = ST_DROPPED;
                end
                default:
                begin
                    state_next = ST_HEADER;
                end
            endcase
        end
    end

    always_comb
    begin
        if (produce)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_HEADER;
            header_bytes_reg <= 24'd0;
            header_index_reg <= 2'd0;
            bytes_left_reg   <= 32'd0;
            max_payload_reg  <= MAX_PAYLOAD_RESET;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            header_bytes_reg <= header_bytes_next;
            header_index_reg <= header_index_next;
            bytes_left_reg   <= bytes_left_next;
            out_valid_reg    <= out_valid_next;
            if (cfg_we)
                max_payload_reg <= cfg_wdata;
        end
    end

    // hold the result until transferred
    always_ff @(posedge clk)
    begin
        if (produce)
        begin
            kind_reg         <= kind_next;
            payload_byte_reg <= payload_byte_next;
            frame_end_reg    <= frame_end_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign kind         = kind_reg;
    assign payload_byte = payload_byte_reg;
    assign frame_end    = frame_end_reg;

    a_drop_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DROPPED |=> state_reg == ST_DROPPED)
        else $error("dropped state left before reset");

    a_error_drops: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && kind_reg == KIND_ERROR |-> state_reg == ST_DROPPED)
        else $error("length error reported without dropping the stream");

    a_payload_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_PAYLOAD |-> bytes_left_reg != 32'd0)
        else $error("payload state with no bytes left");

    a_header_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_HEADER |-> header_index_reg == 2'd0)
        else $error("header bytes gathered outside header state");

endmodule

`default_nettype wire

/* tb/sv/tb_length_prefix_deframer_unit.sv */
`timescale 1ns / 1ps

module tb_length_prefix_deframer_unit;
    import lpd_pkg::*;

    localparam int SETTLE_CYCLES = 4;
    localparam int HOLD_CYCLES   = 50;
    localparam int CYCLE_LIMIT   = 200000;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
        logic       last;
    } deframe_result_t;

    typedef enum logic {
        ROW_BYTE,
        ROW_CFG
    } row_op_t;

    typedef struct packed {
        row_op_t         op;
        logic [31:0]     val;
        logic            typed;
        logic            t_has;
        deframe_result_t t_res;
    } script_row_t;

    localparam deframe_result_t NO_RESULT = '{KIND_BYTE, 8'h00, 1'b0};

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    logic [7:0]  rx_byte   = 8'h00;
    logic        out_valid;
    logic        out_ready = 1'b0;
    kind_t       kind;
    logic [7:0]  payload_byte;
    logic        frame_end;
    logic        cfg_we    = 1'b0;
    logic [31:0] cfg_wdata = 32'h0;

    length_prefix_deframer_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .payload_byte (payload_byte),
        .frame_end    (frame_end),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata)
    );

    // predictor state
    logic [23:0] hdr_acc    = 24'h0;
    logic [1:0]  hdr_cnt    = 2'd0;
    logic [31:0] remain     = 32'h0;
    logic        in_body    = 1'b0;
    logic        is_dropped = 1'b0;
    logic [31:0] max_len    = MAX_PAYLOAD_RESET;

    deframe_result_t expect_q[$];
    int snd_idle  = 33;
    int rcv_idle  = 72;
    int hold_left = 0;
    int errors    = 0;
    int n_in      = 0;
    int n_out     = 0;
    int n_frames  = 0;
    int cycles    = 0;

    script_row_t script [26];

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, expect_q.size());
            $display("length_prefix_deframer_unit test failed");
            $finish;
        end
    end

    function automatic logic deframe_byte(input logic [7:0] b, output deframe_result_t r);
        logic [31:0] total;
        logic [31:0] plen;
        r = NO_RESULT;
        if (is_dropped)
            return 1'b0;
        if (in_body)
        begin
            r.data = b;
            if (remain <= 32'd1)
            begin
                remain  = 32'd0;
                in_body = 1'b0;
                r.last  = 1'b1;
            end
            else
                remain = remain - 32'd1;
            return 1'b1;
        end
        if (hdr_cnt < HDR_LAST_INDEX)
        begin
            hdr_acc = {hdr_acc[15:0], b};
            hdr_cnt = hdr_cnt + 2'd1;
            return 1'b0;
        end
        total   = {hdr_acc, b};
        plen    = total - HDR_LEN;
        hdr_acc = 24'h0;
        hdr_cnt = 2'd0;
        if (plen > max_len)
        begin
            is_dropped = 1'b1;
            r.kind     = KIND_ERROR;
            return 1'b1;
        end
        if (plen == 32'd0)
        begin
            r.kind = KIND_EMPTY;
            r.last = 1'b1;
            return 1'b1;
        end
        remain  = plen;
        in_body = 1'b1;
        return 1'b0;
    endfunction

    function automatic script_row_t raw(input logic [7:0] b);
        return '{ROW_BYTE, {24'h0, b}, 1'b0, 1'b0, NO_RESULT};
    endfunction

    function automatic script_row_t quiet(input logic [7:0] b);
        return '{ROW_BYTE, {24'h0, b}, 1'b1, 1'b0, NO_RESULT};
    endfunction

    function automatic script_row_t gives(input logic [7:0] b, input kind_t k,
                                          input logic [7:0] d, input logic e);
        return '{ROW_BYTE, {24'h0, b}, 1'b1, 1'b1, deframe_result_t'{k, d, e}};
    endfunction

    function automatic script_row_t limit_to(input logic [31:0] v);
        return '{ROW_CFG, v, 1'b0, 1'b0, NO_RESULT};
    endfunction

    function automatic int unsigned pick_len();
        int unsigned cap;
        cap = (max_len > 32'd200) ? 200 : max_len;
        if ($urandom_range(15) == 0)
            return $urandom_range(cap);
        return $urandom_range((cap > 20) ? 20 : cap);
    endfunction

    // hold a byte on the input until it is taken
    task automatic offer(input logic [7:0] b);
        @(negedge clk);
        while ($urandom_range(99) < snd_idle)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic feed(input logic [7:0] b);
        deframe_result_t r;
        offer(b);
        if (deframe_byte(b, r))
            expect_q.push_back(r);
        n_in++;
    endtask

    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expect_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_max(input logic [31:0] v);
        settle();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        max_len    = v;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic send_frame(input logic [31:0] plen);
        logic [31:0] total;
        total = plen + HDR_LEN;
        feed(total[31:24]);
        feed(total[23:16]);
        feed(total[15:8]);
        feed(total[7:0]);
        repeat (plen) feed(8'($urandom_range(255)));
        n_frames++;
    endtask

    task automatic run_frames(input int target);
        while (n_in < target)
            send_frame(pick_len());
    endtask

    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else
                out_ready <= ($urandom_range(99) >= rcv_idle);
        end
    end

    always @(posedge clk)
    begin : check_results
        deframe_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expect_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result kind=%0d byte=%02h end=%0b",
                         $time, kind, payload_byte, frame_end);
            end
            else
            begin
                want = expect_q.pop_front();
                n_out++;
                if ({kind, payload_byte, frame_end} !== want)
                begin
                    errors++;
                    $display("%0t: expected kind=%0d byte=%02h end=%0b, %s",
                             $time, want.kind, want.data, want.last, "got");
                    $display("%0t: got kind=%0d byte=%02h end=%0b",
                             $time, kind, payload_byte, frame_end);
                end
            end
        end
    end

    initial
    begin : stimulus
        int i;
        logic got;
        logic wrapped;
        logic [31:0] bad_total;
        deframe_result_t res;

        script = '{
            quiet(8'h00), quiet(8'h00), quiet(8'h00),
            gives(8'h04, KIND_EMPTY, 8'h00, 1'b1),
            raw(8'h00), raw(8'h00), raw(8'h00), raw(8'h05),
            gives(8'hFF, KIND_BYTE, 8'hFF, 1'b1),
            raw(8'h00), raw(8'h00), raw(8'h00), raw(8'h0A),
            gives(8'h00, KIND_BYTE, 8'h00, 1'b0),
            raw(8'h80), raw(8'h7F),
            limit_to(32'd2),
            raw(8'h55), raw(8'hAA),
            gives(8'h01, KIND_BYTE, 8'h01, 1'b1),
            raw(8'h00), raw(8'h00), raw(8'h00), raw(8'h06),
            raw(8'hFE),
            gives(8'h7E, KIND_BYTE, 8'h7E, 1'b1)
        };

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (i = 0; i < $size(script); i++)
        begin
            if (script[i].op == ROW_CFG)
                set_max(script[i].val);
            else
            begin
                offer(script[i].val[7:0]);
                got = deframe_byte(script[i].val[7:0], res);
                if (script[i].typed)
                begin
                    got = script[i].t_has;
                    res = script[i].t_res;
                end
                if (got)
                    expect_q.push_back(res);
                n_in++;
            end
        end

        set_max(32'd0);
        repeat (8) send_frame(32'd0);
        set_max(32'hFFFF_FFFF);
        hold_left = HOLD_CYCLES;
        send_frame(32'd60);
        run_frames(220);

        snd_idle = 72;
        rcv_idle = 33;
        set_max(32'($urandom_range(32, 1)));
        run_frames(400);

        snd_idle = 0;
        rcv_idle = 0;
        set_max(32'($urandom_range(64, 1)));
        run_frames(520);

        // close the stream with a bad length, then show that it stays dropped
        wrapped   = 1'($urandom_range(1));
        bad_total = wrapped ? 32'($urandom_range(3)) : max_len + HDR_LEN + 32'd1;
        feed(bad_total[31:24]);
        feed(bad_total[23:16]);
        feed(bad_total[15:8]);
        feed(bad_total[7:0]);
        repeat (6) feed(8'($urandom_range(255)));
        set_max(32'hFFFF_FFFF);
        send_frame(32'd0);
        send_frame(32'd3);
        settle();

        $display("%0d stream bytes in %0d frames, %0d results checked", n_in, n_frames, n_out);
        $display("max_payload swept 0 .. all ones, stream ended by a %s length error",
                 wrapped ? "wrapped" : "oversize");
        if (errors == 0 && expect_q.size() == 0)
            $display("length_prefix_deframer_unit test passed");
        else
            $display("length_prefix_deframer_unit test failed");
        $finish;
    end

endmodule
